FILE: hw/rtl/stsc_pkg.sv
// Shared types and constants for the source token scanner.
`default_nettype none

package stsc_pkg;

  localparam int CHAR_W      = 8;
  localparam int LINE_W      = 16;
  localparam int TOK_W       = 16;
  localparam int KW_W        = 64;
  localparam int NUM_KW_REGS = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CNT_W       = 7;   // holds a length up to 64

  // Keyword registers searched on a flush
  localparam int KEYWORD_COUNT = 6;
  localparam int KW_SEARCH     = (KEYWORD_COUNT < NUM_KW_REGS) ? KEYWORD_COUNT : NUM_KW_REGS;

  localparam int MAX_IDENT_LEN_DEF = 16;
  localparam int QUEUE_DEPTH_DEF   = 4;

  // Keywords after reset: int, main, if, else, do, while
  localparam logic [KW_W-1:0] KW_RESET [NUM_KW_REGS] = '{
    64'd7630441, 64'd1852399981, 64'd26217, 64'd1702063205, 64'd28516, 64'd435610544247
  };

  typedef enum logic [2:0] {
    KIND_LINE_CMT    = 3'd0,
    KIND_BLOCK_START = 3'd1,
    KIND_BLOCK_END   = 3'd2,
    KIND_OP          = 3'd3,
    KIND_SPECIAL     = 3'd4,
    KIND_DIGIT       = 3'd5,
    KIND_KEYWORD     = 3'd6,
    KIND_IDENT       = 3'd7
  } kind_t;

  // Commands from the front end to the back end
  typedef enum logic [1:0] {
    OP_TOKEN  = 2'd0,  // one complete token
    OP_ICHAR  = 2'd1,  // store one identifier character at cnt
    OP_IFLUSH = 2'd2   // read out cnt stored identifier characters
  } op_t;

  typedef struct packed {
    op_t                op;
    kind_t              kind;
    logic [LINE_W-1:0]  line;
    logic [TOK_W-1:0]   tok;
    logic [CHAR_W-1:0]  chr;
    logic               trunc;
    logic               last;   // carries the final result of its input item
    logic [CNT_W-1:0]   cnt;
  } cmd_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              end_of_file;
  } in_item_t;

  typedef struct packed {
    kind_t             token_kind;
    logic [LINE_W-1:0] line_number;
    logic [TOK_W-1:0]  token_number;
    logic [CHAR_W-1:0] lexeme_char;
    logic              token_end;
    logic              truncated;
    logic              step_end;
  } out_item_t;

endpackage

`default_nettype wire

FILE: hw/rtl/stsc_queue.sv
// Command queue between the scanner front end and the result back end.
`default_nettype none

module stsc_queue import stsc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t wdata,
  output logic      full,
  input  wire logic pop,
  output cmd_t      head,
  output logic      head_valid
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/stsc_front.sv
// Scanner front end: accepts bytes, tracks lexer state and queues commands.
`default_nettype none

module stsc_front import stsc_pkg::*; #(
  parameter int MAX_IDENT_LEN = MAX_IDENT_LEN_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [KW_W-1:0]      cfg_data,
  input  wire logic                 q_full,
  output logic                      q_push,
  output cmd_t                      q_wdata
);

  localparam int LW = $clog2(MAX_IDENT_LEN + 1);

  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_LBRC  = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RBRC  = 8'h7D;
  localparam logic [CHAR_W-1:0] CH_LPAR  = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAR  = 8'h29;
  localparam logic [CHAR_W-1:0] CH_QUEST = 8'h3F;
  localparam logic [CHAR_W-1:0] CH_AT    = 8'h40;
  localparam logic [CHAR_W-1:0] CH_BANG  = 8'h21;
  localparam logic [CHAR_W-1:0] CH_PCT   = 8'h25;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;

  typedef enum logic [2:0] {
    M_NORMAL = 3'd0,
    M_SLASH  = 3'd1,
    M_LINE   = 3'd2,
    M_BLOCK  = 3'd3,
    M_IDENT  = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_SLASH,
    CLS_OP,
    CLS_SPECIAL,
    CLS_DIGIT,
    CLS_LETTER,
    CLS_NEWLINE
  } class_t;

  function automatic class_t classify(input logic [CHAR_W-1:0] c);
    class_t k;
    k = CLS_OTHER;
    if (c == CH_SLASH) begin
      k = CLS_SLASH;
    end else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR) begin
      k = CLS_OP;
    end else if (c == CH_SEMI || c == CH_LBRC || c == CH_RBRC || c == CH_LPAR ||
                 c == CH_RPAR || c == CH_QUEST || c == CH_AT || c == CH_BANG ||
                 c == CH_PCT) begin
      k = CLS_SPECIAL;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      k = CLS_DIGIT;
    end else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)) begin
      k = CLS_LETTER;
    end else if (c == CH_NL) begin
      k = CLS_NEWLINE;
    end
    return k;
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] x);
    return (x == 16'hFFFF) ? x : x + 16'd1;
  endfunction

  function automatic cmd_t mk_cmd(input op_t op, input kind_t kind,
                                  input logic [LINE_W-1:0] line,
                                  input logic [TOK_W-1:0] tok,
                                  input logic [CHAR_W-1:0] chr, input logic trunc,
                                  input logic [CNT_W-1:0] cnt);
    cmd_t e;
    e.op    = op;
    e.kind  = kind;
    e.line  = line;
    e.tok   = tok;
    e.chr   = chr;
    e.trunc = trunc;
    e.last  = 1'b0;
    e.cnt   = cnt;
    return e;
  endfunction

  logic [KW_W-1:0]    kw_r [NUM_KW_REGS];
  mode_t              mode_r, mode_nxt;
  logic               pstar_r, pstar_nxt;
  logic [LINE_W-1:0]  line_r, line_nxt;
  logic [TOK_W-1:0]   tok_r, tok_nxt;
  logic [LW-1:0]      len_r, len_nxt;
  logic               ovf_r, ovf_nxt;
  logic [7:0][7:0]    packed_r, packed_nxt;
  logic               pend_v_r, pend_v_nxt;
  cmd_t               pend_r, pend_nxt;

  logic               accept;
  logic               kw_hit;
  kind_t              fl_kind;
  logic               fl_trunc;
  class_t             cls;
  logic [CHAR_W-1:0]  c;
  cmd_t               e_a, e_b, e_n;
  logic               v_a, v_b, v_n;
  logic               do_norm;
  logic [TOK_W-1:0]   tok_v;

  assign in_stall = pend_v_r || q_full;
  assign accept   = in_valid && !in_stall;
  assign c        = in_data.char_code;
  assign cls      = classify(c);

  // Compare the packed identifier against the keyword registers
  always_comb begin
    kw_hit = 1'b0;
    for (int j = 0; j < KW_SEARCH; j++) begin
      if (kw_r[j] == packed_r) begin
        kw_hit = 1'b1;
      end
    end
  end

  assign fl_kind  = (!ovf_r && len_r <= LW'(8) && kw_hit) ? KIND_KEYWORD : KIND_IDENT;
  assign fl_trunc = (fl_kind == KIND_IDENT) && ovf_r;

  // Classify one item into at most two commands and the next lexer state
  always_comb begin
    mode_nxt   = mode_r;
    pstar_nxt  = pstar_r;
    line_nxt   = line_r;
    len_nxt    = len_r;
    ovf_nxt    = ovf_r;
    packed_nxt = packed_r;
    tok_v      = tok_r;
    e_a        = '0;
    e_b        = '0;
    e_n        = '0;
    v_a        = 1'b0;
    v_b        = 1'b0;
    v_n        = 1'b0;
    do_norm    = 1'b0;

    if (in_data.end_of_file) begin
      case (mode_r)
        M_SLASH: begin
          e_a   = mk_cmd(OP_TOKEN, KIND_OP, line_r, tok_v, CH_SLASH, 1'b0, '0);
          v_a   = 1'b1;
          tok_v = sat_inc(tok_v);
        end
        M_BLOCK: begin
          e_a   = mk_cmd(OP_TOKEN, KIND_BLOCK_END, line_r, tok_v, '0, 1'b0, '0);
          v_a   = 1'b1;
          tok_v = sat_inc(tok_v);
        end
        M_IDENT: begin
          e_a     = mk_cmd(OP_IFLUSH, fl_kind, line_r, tok_v, '0, fl_trunc, CNT_W'(len_r));
          v_a     = 1'b1;
          tok_v   = sat_inc(tok_v);
          len_nxt = '0;
          ovf_nxt = 1'b0;
        end
        default: ;
      endcase
      mode_nxt  = M_NORMAL;
      pstar_nxt = 1'b0;
    end else begin
      case (mode_r)
        M_SLASH: begin
          if (c == CH_SLASH) begin
            e_a      = mk_cmd(OP_TOKEN, KIND_LINE_CMT, line_r, tok_v, '0, 1'b0, '0);
            v_a      = 1'b1;
            tok_v    = sat_inc(tok_v);
            mode_nxt = M_LINE;
          end else if (c == CH_STAR) begin
            e_a       = mk_cmd(OP_TOKEN, KIND_BLOCK_START, line_r, tok_v, '0, 1'b0, '0);
            v_a       = 1'b1;
            tok_v     = sat_inc(tok_v);
            mode_nxt  = M_BLOCK;
            pstar_nxt = 1'b0;
          end else begin
            // Lone slash: report it, then scan this byte afresh
            e_a     = mk_cmd(OP_TOKEN, KIND_OP, line_r, tok_v, CH_SLASH, 1'b0, '0);
            v_a     = 1'b1;
            tok_v   = sat_inc(tok_v);
            do_norm = 1'b1;
          end
        end
        M_LINE: begin
          if (c == CH_NL) begin
            line_nxt = sat_inc(line_r);
            mode_nxt = M_NORMAL;
          end
        end
        M_BLOCK: begin
          if (pstar_r && c == CH_SLASH) begin
            e_a       = mk_cmd(OP_TOKEN, KIND_BLOCK_END, line_r, tok_v, '0, 1'b0, '0);
            v_a       = 1'b1;
            tok_v     = sat_inc(tok_v);
            mode_nxt  = M_NORMAL;
            pstar_nxt = 1'b0;
          end else begin
            if (c == CH_NL) begin
              line_nxt = sat_inc(line_r);
            end
            pstar_nxt = (c == CH_STAR);
          end
        end
        M_IDENT: begin
          if (cls == CLS_LETTER || cls == CLS_DIGIT) begin
            if (len_r < LW'(MAX_IDENT_LEN)) begin
              e_a = mk_cmd(OP_ICHAR, KIND_IDENT, line_r, tok_v, c, 1'b0, CNT_W'(len_r));
              v_a = 1'b1;
              if (len_r < LW'(8)) begin
                packed_nxt[len_r[2:0]] = c;
              end
              len_nxt = len_r + LW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end else begin
            // Identifier ends: flush it, then scan this byte afresh
            e_a     = mk_cmd(OP_IFLUSH, fl_kind, line_r, tok_v, '0, fl_trunc, CNT_W'(len_r));
            v_a     = 1'b1;
            tok_v   = sat_inc(tok_v);
            len_nxt = '0;
            ovf_nxt = 1'b0;
            do_norm = 1'b1;
          end
        end
        default: do_norm = 1'b1;
      endcase
    end

    // Scan a byte in normal mode
    if (do_norm) begin
      mode_nxt = M_NORMAL;
      case (cls)
        CLS_SLASH: mode_nxt = M_SLASH;
        CLS_OP: begin
          e_n   = mk_cmd(OP_TOKEN, KIND_OP, line_r, tok_v, c, 1'b0, '0);
          v_n   = 1'b1;
          tok_v = sat_inc(tok_v);
        end
        CLS_SPECIAL: begin
          e_n   = mk_cmd(OP_TOKEN, KIND_SPECIAL, line_r, tok_v, c, 1'b0, '0);
          v_n   = 1'b1;
          tok_v = sat_inc(tok_v);
        end
        CLS_DIGIT: begin
          e_n   = mk_cmd(OP_TOKEN, KIND_DIGIT, line_r, tok_v, c, 1'b0, '0);
          v_n   = 1'b1;
          tok_v = sat_inc(tok_v);
        end
        CLS_LETTER: begin
          e_n        = mk_cmd(OP_ICHAR, KIND_IDENT, line_r, tok_v, c, 1'b0, '0);
          v_n        = 1'b1;
          packed_nxt = '0;
          packed_nxt[0] = c;
          len_nxt    = LW'(1);
          ovf_nxt    = 1'b0;
          mode_nxt   = M_IDENT;
        end
        CLS_NEWLINE: line_nxt = sat_inc(line_r);
        default: ;
      endcase
    end

    // Place the normal-mode command behind any earlier one
    if (v_n) begin
      if (v_a) begin
        e_b = e_n;
        v_b = 1'b1;
      end else begin
        e_a = e_n;
        v_a = 1'b1;
      end
    end

    // Mark the command that carries the item's final result
    if (v_b && e_b.op != OP_ICHAR) begin
      e_b.last = 1'b1;
    end else if (v_a && e_a.op != OP_ICHAR) begin
      e_a.last = 1'b1;
    end

    tok_nxt = tok_v;
  end

  // Queue the first command at once, hold the second until the queue has room
  assign q_push  = pend_v_r ? !q_full : (accept && v_a);
  assign q_wdata = pend_v_r ? pend_r : e_a;

  always_comb begin
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    if (pend_v_r && !q_full) begin
      pend_v_nxt = 1'b0;
    end
    if (accept && v_b) begin
      pend_v_nxt = 1'b1;
      pend_nxt   = e_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_NORMAL;
      pstar_r  <= 1'b0;
      line_r   <= LINE_W'(1);
      tok_r    <= '0;
      len_r    <= '0;
      ovf_r    <= 1'b0;
      pend_v_r <= 1'b0;
      for (int i = 0; i < NUM_KW_REGS; i++) begin
        kw_r[i] <= KW_RESET[i];
      end
    end else begin
      pend_v_r <= pend_v_nxt;
      if (cfg_we && cfg_index < CFG_IDX_W'(NUM_KW_REGS)) begin
        kw_r[cfg_index] <= cfg_data;
      end
      if (accept) begin
        mode_r  <= mode_nxt;
        pstar_r <= pstar_nxt;
        line_r  <= line_nxt;
        tok_r   <= tok_nxt;
        len_r   <= len_nxt;
        ovf_r   <= ovf_nxt;
      end
    end
  end

  // Identifier pack and held command need no reset
  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    if (accept) begin
      packed_r <= packed_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/stsc_back.sv
// Scanner back end: executes queued commands and drives the result register.
`default_nettype none

module stsc_back import stsc_pkg::*; #(
  parameter int MAX_IDENT_LEN = MAX_IDENT_LEN_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cmd_t head,
  input  wire logic head_valid,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_item_t out_data
);

  localparam int IW = $clog2(MAX_IDENT_LEN);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_EMIT
  } state_t;

  logic [CHAR_W-1:0] ident_mem [MAX_IDENT_LEN];
  logic [CHAR_W-1:0] rd_data_r;

  state_t            state_r, state_nxt;
  logic [IW-1:0]     rd_idx_r, rd_idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;
  logic              load;
  logic              rd_last;
  logic              mem_we;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign load      = !out_valid_r || !out_stall;
  assign rd_last   = (CNT_W'(rd_idx_r) + CNT_W'(1)) == head.cnt;

  // Sequence commands: tokens in one step, identifiers a character at a time
  always_comb begin
    state_nxt     = state_r;
    rd_idx_nxt    = rd_idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    pop           = 1'b0;
    mem_we        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (head_valid) begin
          case (head.op)
            OP_TOKEN: begin
              if (load) begin
                out_valid_nxt             = 1'b1;
                out_data_nxt.token_kind   = head.kind;
                out_data_nxt.line_number  = head.line;
                out_data_nxt.token_number = head.tok;
                out_data_nxt.lexeme_char  = head.chr;
                out_data_nxt.token_end    = 1'b1;
                out_data_nxt.truncated    = head.trunc;
                out_data_nxt.step_end     = head.last;
                pop                       = 1'b1;
              end
            end
            OP_ICHAR: begin
              mem_we = 1'b1;
              pop    = 1'b1;
            end
            OP_IFLUSH: begin
              rd_idx_nxt = '0;
              state_nxt  = S_FETCH;
            end
            default: pop = 1'b1;
          endcase
        end
      end
      S_FETCH: state_nxt = S_EMIT;
      S_EMIT: begin
        if (load) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.token_kind   = head.kind;
          out_data_nxt.line_number  = head.line;
          out_data_nxt.token_number = head.tok;
          out_data_nxt.lexeme_char  = rd_data_r;
          out_data_nxt.token_end    = rd_last;
          out_data_nxt.truncated    = head.trunc;
          out_data_nxt.step_end     = head.last && rd_last;
          if (rd_last) begin
            pop       = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            rd_idx_nxt = rd_idx_r + IW'(1);
            state_nxt  = S_FETCH;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    rd_idx_r   <= rd_idx_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Identifier buffer: write on store commands, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ident_mem[head.cnt[IW-1:0]] <= head.chr;
    end
    rd_data_r <= ident_mem[rd_idx_r];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/source_token_scanner.sv
// Top level of the source token scanner: front end, command queue, back end.
//
//  port group | direction | handshake           | payload
//  -----------+-----------+---------------------+-------------------------------
//  in_        | input     | in_valid/in_stall   | in_item_t: char_code, end_of_file
//  out_       | output    | out_valid/out_stall | out_item_t: token fields
//  cfg_       | input     | cfg_we              | cfg_index, cfg_data (keywords)
//
// The front end takes an item while in_stall is low; an item that closes a token and
// starts another writes two commands, the second held in a pending register that keeps
// in_stall high until it is queued. The back end sends a simple token or stores an
// identifier character in one step; it reads out N stored identifier characters
// with a start step, then a fetch and an emit state per character, through the
// registered buffer read. Reset clears lexer mode, counters, queue and output
// valid; the identifier buffer holds old data. out_stall holds the output
// register; the queue absorbs up to QUEUE_DEPTH commands before in_stall rises.
`default_nettype none

module source_token_scanner import stsc_pkg::*; #(
  parameter int MAX_IDENT_LEN = MAX_IDENT_LEN_DEF,
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [KW_W-1:0]      cfg_data
);

  logic q_full;
  logic q_push;
  cmd_t q_wdata;
  logic q_pop;
  cmd_t q_head;
  logic q_valid;

  stsc_front #(.MAX_IDENT_LEN(MAX_IDENT_LEN)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  stsc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .wdata      (q_wdata),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_valid)
  );

  stsc_back #(.MAX_IDENT_LEN(MAX_IDENT_LEN)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .head_valid (q_valid),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  // Front end never writes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_full && q_push))
    else $error("command written into full queue");

  // Back end only retires a command that is present
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("command retired from empty queue");

  // Tokens other than identifiers and keywords are single results
  a_simple_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.token_kind != KIND_IDENT &&
     out_data.token_kind != KIND_KEYWORD) |-> out_data.token_end)
    else $error("simple token result without token end");

endmodule

`default_nettype wire

FILE: tb/source_token_scanner_tb.sv
// Self-checking testbench for the source token scanner: directed and random byte streams.
module source_token_scanner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stsc_pkg::*;

  localparam int MAX_WORD     = MAX_IDENT_LEN_DEF;
  localparam int DRAIN_CYCLES = 64;
  localparam int IDLE_LIMIT   = 200000;

  localparam logic [CFG_IDX_W-1:0] REG_KEYWORD_0 = '0;
  localparam int REG_FIRST_UNUSED = NUM_KW_REGS;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_A = 8'h41;

  localparam string OPERATORS = "+-*";
  localparam string SPECIALS  = ";{}()?@!%";

  typedef enum logic [2:0] {
    SCAN_NORMAL, SCAN_SLASH, SCAN_LINE, SCAN_BLOCK, SCAN_IDENT
  } scan_mode_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BURST} stall_style_t;

  // DUT connections
  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [KW_W-1:0]      cfg_data  = '0;

  // Scanner model state
  scan_mode_t       scan_state;
  logic             prev_star;
  logic [15:0]      line_cnt;
  logic [15:0]      tok_cnt;
  logic [7:0]       word_buf [MAX_WORD];
  int               word_len;
  logic             word_over;
  logic [KW_W-1:0]  keywords [NUM_KW_REGS];

  out_item_t expected_tokens[$];
  out_item_t step_buf[$];

  int  error_count     = 0;
  int  results_checked = 0;
  int  items_sent      = 0;
  int  kw_writes       = 0;
  bit  no_gaps         = 1'b0;

  int           stall_left  = 0;
  int           stall_hold  = 0;
  stall_style_t stall_style = STALL_NONE;

  source_token_scanner i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Scanner model
  // ---------------------------------------------------------------------------
  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [15:0] claim_token_number();
    logic [15:0] num;
    num = tok_cnt;
    if (tok_cnt != 16'hFFFF) tok_cnt++;
    return num;
  endfunction

  function automatic void push_token_result(kind_t kind, logic [15:0] num, logic [7:0] ch,
                                            logic tend, logic trunc);
    out_item_t r;
    r.token_kind   = kind;
    r.line_number  = line_cnt;
    r.token_number = num;
    r.lexeme_char  = ch;
    r.token_end    = tend;
    r.truncated    = trunc;
    r.step_end     = 1'b0;
    step_buf.push_back(r);
  endfunction

  function automatic void push_simple(kind_t kind, logic [7:0] ch);
    push_token_result(kind, claim_token_number(), ch, 1'b1, 1'b0);
  endfunction

  function automatic void bump_line();
    if (line_cnt != 16'hFFFF) line_cnt++;
  endfunction

  // Read out the stored word; short, uncut words are looked up as keywords
  function automatic void flush_word();
    kind_t           kind;
    logic [KW_W-1:0] kw_image;
    logic [15:0]     num;
    kind = KIND_IDENT;
    if (!word_over && word_len <= 8) begin
      kw_image = '0;
      for (int i = 0; i < word_len; i++) kw_image[8*i +: 8] = word_buf[i];
      for (int j = 0; j < KW_SEARCH; j++)
        if (keywords[j] == kw_image) kind = KIND_KEYWORD;
    end
    num = claim_token_number();
    for (int i = 0; i < word_len; i++)
      push_token_result(kind, num, word_buf[i], i + 1 == word_len,
                        (kind == KIND_IDENT) ? word_over : 1'b0);
    word_len   = 0;
    word_over  = 1'b0;
    scan_state = SCAN_NORMAL;
  endfunction

  function automatic void scan_plain_byte(logic [7:0] c);
    bit is_special;
    is_special = 1'b0;
    for (int i = 0; i < SPECIALS.len(); i++)
      if (c == SPECIALS[i]) is_special = 1'b1;
    scan_state = SCAN_NORMAL;
    if (c == CH_SLASH) begin
      scan_state = SCAN_SLASH;
    end else if (c == "+" || c == "-" || c == CH_STAR) begin
      push_simple(KIND_OP, c);
    end else if (is_special) begin
      push_simple(KIND_SPECIAL, c);
    end else if (is_digit(c)) begin
      push_simple(KIND_DIGIT, c);
    end else if (is_letter(c)) begin
      word_buf[0] = c;
      word_len    = 1;
      word_over   = 1'b0;
      scan_state  = SCAN_IDENT;
    end else if (c == CH_NEWLINE) begin
      bump_line();
    end
  endfunction

  // Advance the model by one accepted item and queue the tokens it yields
  function automatic void advance_scanner(in_item_t it);
    logic [7:0] c;
    out_item_t  r;
    c = it.char_code;
    step_buf.delete();
    if (it.end_of_file) begin
      case (scan_state)
        SCAN_SLASH: push_simple(KIND_OP, CH_SLASH);
        SCAN_BLOCK: push_simple(KIND_BLOCK_END, 8'h00);
        SCAN_IDENT: flush_word();
        default: ;
      endcase
      scan_state = SCAN_NORMAL;
      prev_star  = 1'b0;
    end else begin
      case (scan_state)
        SCAN_SLASH: begin
          if (c == CH_SLASH) begin
            push_simple(KIND_LINE_CMT, 8'h00);
            scan_state = SCAN_LINE;
          end else if (c == CH_STAR) begin
            push_simple(KIND_BLOCK_START, 8'h00);
            scan_state = SCAN_BLOCK;
            prev_star  = 1'b0;
          end else begin
            push_simple(KIND_OP, CH_SLASH);
            scan_plain_byte(c);
          end
        end
        SCAN_LINE: begin
          if (c == CH_NEWLINE) begin
            bump_line();
            scan_state = SCAN_NORMAL;
          end
        end
        SCAN_BLOCK: begin
          if (prev_star && c == CH_SLASH) begin
            push_simple(KIND_BLOCK_END, 8'h00);
            scan_state = SCAN_NORMAL;
            prev_star  = 1'b0;
          end else begin
            if (c == CH_NEWLINE) bump_line();
            prev_star = (c == CH_STAR);
          end
        end
        SCAN_IDENT: begin
          if (is_letter(c) || is_digit(c)) begin
            if (word_len < MAX_WORD) begin
              word_buf[word_len] = c;
              word_len++;
            end else begin
              word_over = 1'b1;
            end
          end else begin
            flush_word();
            scan_plain_byte(c);
          end
        end
        default: scan_plain_byte(c);
      endcase
    end
    if (step_buf.size() > 0) begin
      r = step_buf.pop_back();
      r.step_end = 1'b1;
      step_buf.push_back(r);
    end
    foreach (step_buf[i]) expected_tokens.push_back(step_buf[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  function automatic void report_mismatch(string msg);
    error_count++;
    if (error_count <= 40) $display("[%0t] MISMATCH: %s", $time, msg);
  endfunction

  function automatic void check_field(string name, logic [15:0] got, logic [15:0] want_val,
                                      logic [15:0] num);
    if (got !== want_val)
      report_mismatch($sformatf("token %0d %s: got %0h, want %0h", num, name, got, want_val));
  endfunction

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_tokens.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: kind %0d char %0h",
                                  out_data.token_kind, out_data.lexeme_char));
      end else begin
        want = expected_tokens.pop_front();
        results_checked++;
        check_field("kind", 16'(out_data.token_kind), 16'(want.token_kind), want.token_number);
        check_field("line", out_data.line_number, want.line_number, want.token_number);
        check_field("number", out_data.token_number, want.token_number, want.token_number);
        check_field("char", 16'(out_data.lexeme_char), 16'(want.lexeme_char),
                    want.token_number);
        check_field("token_end", 16'(out_data.token_end), 16'(want.token_end),
                    want.token_number);
        check_field("truncated", 16'(out_data.truncated), 16'(want.truncated),
                    want.token_number);
        check_field("step_end", 16'(out_data.step_end), 16'(want.step_end), want.token_number);
      end
    end
  end

  // Result-side stall: phases of no stall, light, heavy and long bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_style = stall_style_t'($urandom_range(0, 3));
        stall_left  = $urandom_range(16, 160);
      end
      stall_left--;
      case (stall_style)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default: begin
          if (stall_hold > 0) begin
            stall_hold--;
            out_stall <= 1'b1;
          end else if ($urandom_range(0, 30) == 0) begin
            stall_hold = $urandom_range(8, 40);
            out_stall <= 1'b1;
          end else begin
            out_stall <= 1'b0;
          end
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one item, hold it until taken, then update the model
  task automatic send_item(input in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_scanner(it);
    items_sent++;
  endtask

  task automatic send_char(input logic [7:0] c);
    in_item_t it;
    it.char_code   = c;
    it.end_of_file = 1'b0;
    send_item(it);
  endtask

  task automatic send_eof(input logic [7:0] c);
    in_item_t it;
    it.char_code   = c;
    it.end_of_file = 1'b1;
    send_item(it);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Drop valid, let every pending token drain, then allow for silent work
  task automatic wait_idle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (expected_tokens.size() != 0 && waited < IDLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_keyword(input int idx, input logic [KW_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx[CFG_IDX_W-1:0];
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx < NUM_KW_REGS) keywords[idx] = value;
    kw_writes++;
  endtask

  function automatic logic [KW_W-1:0] pack_word(string s);
    logic [KW_W-1:0] w;
    w = '0;
    for (int i = 0; i < s.len() && i < 8; i++) w[8*i +: 8] = s[i];
    return w;
  endfunction

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 1)) return 8'(CH_LOWER_A + $urandom_range(0, 25));
    return 8'(CH_UPPER_A + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_alnum();
    int r;
    r = $urandom_range(0, 61);
    if (r < 26) return 8'(CH_LOWER_A + r);
    if (r < 52) return 8'(CH_UPPER_A + r - 26);
    return 8'(CH_ZERO + r - 52);
  endfunction

  // Length of a register value read as an identifier, 0 if it is not one
  function automatic int keyword_length(logic [KW_W-1:0] w);
    int n;
    n = 0;
    while (n < 8 && w[8*n +: 8] != 8'h00) n++;
    if (n == 0 || !is_letter(w[7:0])) return 0;
    for (int i = n; i < 8; i++)
      if (w[8*i +: 8] != 8'h00) return 0;
    for (int i = 1; i < n; i++)
      if (!is_letter(w[8*i +: 8]) && !is_digit(w[8*i +: 8])) return 0;
    return n;
  endfunction

  function automatic logic [KW_W-1:0] random_keyword();
    logic [KW_W-1:0] w;
    int              r;
    int              n;
    r = $urandom_range(0, 9);
    if (r < 7) begin
      n = $urandom_range(1, 8);
      w = '0;
      w[7:0] = rand_letter();
      for (int i = 1; i < n; i++) w[8*i +: 8] = rand_alnum();
    end else if (r == 7) begin
      w = '0;
    end else if (r == 8) begin
      w = '1;
    end else begin
      w = {$urandom, $urandom};
    end
    return w;
  endfunction

  // Identifier with random content, sometimes one of the current keywords
  task automatic send_random_word(output int n);
    int j;
    int len;
    int r;
    j   = $urandom_range(0, NUM_KW_REGS - 1);
    len = keyword_length(keywords[j]);
    if ($urandom_range(0, 4) == 0 && len > 0) begin
      for (int i = 0; i < len; i++) send_char(keywords[j][8*i +: 8]);
      send_char(CH_SPACE);
      n = len;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 80) n = $urandom_range(1, 6);
      else if (r < 92) n = $urandom_range(7, 12);
      else n = $urandom_range(13, 22);
      send_char(rand_letter());
      for (int i = 1; i < n; i++) send_char(rand_alnum());
    end
  endtask

  // Mostly well-formed tokens with random content, some noise and broken comments
  task automatic random_tokens(input int quota);
    int counted;
    int r;
    int n;
    logic [7:0] c;
    counted = 0;
    while (counted < quota) begin
      r = $urandom_range(0, 99);
      if (r < 28) begin
        send_random_word(n);
        counted += n;
      end else if (r < 38) begin
        send_char(8'(CH_ZERO + $urandom_range(0, 9)));
        counted++;
      end else if (r < 48) begin
        send_char(OPERATORS[$urandom_range(0, 2)]);
        counted++;
      end else if (r < 58) begin
        send_char(SPECIALS[$urandom_range(0, 8)]);
        counted++;
      end else if (r < 63) begin
        send_char(CH_SLASH);
        counted++;
      end else if (r < 70) begin
        send_text("//");
        n = $urandom_range(0, 8);
        for (int i = 0; i < n; i++) begin
          c = 8'($urandom_range(0, 255));
          send_char(c == CH_NEWLINE ? CH_SPACE : c);
        end
        send_char(CH_NEWLINE);
        counted += n + 3;
      end else if (r < 78) begin
        send_text("/*");
        n = $urandom_range(0, 10);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(0, 7))
            0, 1:    send_char(CH_STAR);
            2:       send_char(CH_SLASH);
            3:       send_char(CH_NEWLINE);
            default: send_char(8'($urandom_range(0, 255)));
          endcase
        end
        send_text("*/");
        counted += n + 4;
      end else if (r < 83) begin
        send_char(CH_NEWLINE);
        counted++;
      end else if (r < 92) begin
        send_char(8'($urandom_range(0, 255)));
        counted++;
      end else if (r < 95) begin
        // unterminated comment opener
        send_text("/*");
        counted += 2;
      end else if (r < 98) begin
        send_eof(8'($urandom_range(0, 255)));
        counted++;
      end else begin
        // hold off until every pending token is out
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_tokens.size() != 0);
      end
      case ($urandom_range(0, 5))
        0:       send_char(CH_SPACE);
        1:       send_char(CH_NEWLINE);
        2:       send_char(CH_TAB);
        default: ;
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_operators_and_symbols();
    send_text("+-*;{}()?@!%09");
  endtask

  // Keyword ending at a slash, lone slash, line comment, block comment whose
  // opening star must not close it, newline inside a block comment
  task automatic test_slashes_and_comments();
    send_text("if/1//\n/*/*\n*/");
  endtask

  // Flush of each pending state at end of file; the byte field is ignored there
  task automatic test_end_of_file();
    send_text("x");
    send_eof(8'hFF);
    send_text("/");
    send_eof(8'h00);
    send_text("/*");
    send_eof(CH_SLASH);
    send_text("//");
    send_eof(8'h00);
    send_eof(8'hFF);
  endtask

  task automatic test_long_identifiers();
    send_text("abcdefghijklmnop;Q123456789abcdefghij+while;");
    send_text("zzzzzzzzzzzzzzzzzz");
    send_eof(8'h00);
  endtask

  task automatic test_keyword_registers();
    wait_idle();
    write_keyword(REG_KEYWORD_0 + 0, pack_word("abcdefgh"));
    write_keyword(REG_KEYWORD_0 + 1, '0);
    write_keyword(REG_KEYWORD_0 + 2, '1);
    write_keyword(REG_KEYWORD_0 + 3, pack_word("A"));
    write_keyword(REG_KEYWORD_0 + 4, pack_word("Zz9"));
    write_keyword(REG_KEYWORD_0 + 5, pack_word("x7"));
    // indexes past the register file change nothing
    write_keyword(REG_FIRST_UNUSED, pack_word("main"));
    write_keyword(REG_FIRST_UNUSED + 1, '1);
    send_text("abcdefgh abcdefghi A Zz9 main x7 int;");
    send_eof(8'h00);
    wait_idle();
  endtask

  task automatic test_random_streams();
    for (int phase = 0; phase < 3; phase++) begin
      for (int i = 0; i < NUM_KW_REGS; i++) begin
        if (phase == 0) write_keyword(REG_KEYWORD_0 + i, KW_RESET[i]);
        else if (phase == 2 && i == 0) write_keyword(REG_KEYWORD_0 + i, '0);
        else if (phase == 2 && i == 1) write_keyword(REG_KEYWORD_0 + i, '1);
        else write_keyword(REG_KEYWORD_0 + i, random_keyword());
      end
      no_gaps = (phase == 1);
      random_tokens(55);
      send_eof(8'($urandom_range(0, 255)));
      no_gaps = 1'b0;
      wait_idle();
    end
  endtask

  initial begin : run_tests
    scan_state = SCAN_NORMAL;
    prev_star  = 1'b0;
    line_cnt   = 16'd1;
    tok_cnt    = 16'd0;
    word_len   = 0;
    word_over  = 1'b0;
    for (int i = 0; i < NUM_KW_REGS; i++) keywords[i] = KW_RESET[i];

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    test_operators_and_symbols();
    test_slashes_and_comments();
    test_end_of_file();
    test_long_identifiers();
    test_keyword_registers();
    test_random_streams();
    wait_idle();

    if (expected_tokens.size() != 0)
      report_mismatch($sformatf("%0d tokens never arrived", expected_tokens.size()));

    $display("Covered %0d input items across %0d keyword register writes;",
             items_sent, kw_writes);
    $display("checked %0d tokens from comments, symbols, identifiers and end-of-file flushes.",
             results_checked);
    if (error_count == 0) begin
      $display("source_token_scanner regression: pass");
    end else begin
      $display("source_token_scanner regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(40_000_000);
    $display("Watchdog expired with %0d tokens pending", expected_tokens.size());
    $display("source_token_scanner regression: fail");
    $finish;
  end

endmodule
